// ===== rtl/rwvh_pkg.sv =====
// Shared types, codes and constants of the random walk visit histogram.
package rwvh_pkg;

  localparam int GRID_SIZE_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int COORD_W     = 10;
  localparam int LIMIT_W     = 16;
  localparam int OUT_COUNT_W = 32;
  localparam int PIXEL_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COORD_W-1:0] START_X_RST    = 10'd512;
  localparam logic [COORD_W-1:0] START_Y_RST    = 10'd0;
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 16'd3000;

  // floor(n / 10) = (n * PIX_RECIP) >> PIX_SHIFT for n below PIX_SAT
  localparam int                 PIX_IN_W  = 12;
  localparam int                 PIX_PROD_W = 24;
  localparam int                 PIX_SHIFT = 15;
  localparam logic [PIX_IN_W-1:0] PIX_RECIP = 12'd3277;
  localparam logic [63:0]        PIX_SAT   = 64'd2560;
  localparam logic [PIXEL_W-1:0] PIX_MAX   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 2'd0,
    REG_START_Y    = 2'd1,
    REG_STEP_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_STEP = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_PIX
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic calc;
    logic pix;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } stat_t;

endpackage

// ===== rtl/rwvh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rwvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rwvh_ctrl.sv =====
// Controller state machine sequencing clear, read, update and output.
module rwvh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rwvh_pkg::stat_t stat,
  output rwvh_pkg::cmd_t  cmd
);

  rwvh_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwvh_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      rwvh_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_nxt = rwvh_pkg::ST_IDLE;
        end
      end
      rwvh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rwvh_pkg::ST_READ;
        end
      end
      rwvh_pkg::ST_READ: begin
        state_nxt = rwvh_pkg::ST_CALC;
      end
      rwvh_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = rwvh_pkg::ST_PIX;
      end
      rwvh_pkg::ST_PIX: begin
        if (!out_valid_r || out_ready) begin
          cmd.pix       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rwvh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rwvh_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rwvh_dp.sv =====
// Datapath: configuration, walker state, histogram memory and result registers.
module rwvh_dp #(
  parameter int GRID_SIZE   = rwvh_pkg::GRID_SIZE_DEF,
  parameter int COUNT_WIDTH = rwvh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rwvh_pkg::cmd_t                      cmd,
  output rwvh_pkg::stat_t                     stat,
  input  logic                                in_kind,
  input  logic [1:0]                          in_direction,
  input  logic [rwvh_pkg::COORD_W-1:0]        in_cell_x,
  input  logic [rwvh_pkg::COORD_W-1:0]        in_cell_y,
  output logic [rwvh_pkg::COORD_W-1:0]        out_pos_x,
  output logic [rwvh_pkg::COORD_W-1:0]        out_pos_y,
  output logic [rwvh_pkg::OUT_COUNT_W-1:0]    out_count,
  output logic [rwvh_pkg::PIXEL_W-1:0]        out_pixel,
  input  logic                                cfg_we,
  input  logic [rwvh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwvh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [CW-1:0] clamp_coord(input logic [rwvh_pkg::COORD_W-1:0] v);
    if (32'(v) >= GRID_SIZE) begin
      return CW'(GRID_SIZE - 1);
    end
    return CW'(v);
  endfunction

  logic [rwvh_pkg::COORD_W-1:0] start_x_r, start_y_r;
  logic [rwvh_pkg::LIMIT_W-1:0] step_limit_r;
  logic [CW-1:0]                walker_x_r, walker_y_r, walker_x_nxt, walker_y_nxt;
  logic [rwvh_pkg::LIMIT_W-1:0] steps_r, steps_nxt;
  logic [AW-1:0]                clr_addr_r;
  rwvh_pkg::kind_t              kind_r;
  rwvh_pkg::dir_t               dir_r;
  logic [rwvh_pkg::COORD_W-1:0] cell_x_r, cell_y_r;
  logic [COUNT_WIDTH-1:0]       cnt_r, cnt_nxt;
  logic [rwvh_pkg::COORD_W-1:0] pos_x_r, pos_y_r;
  logic [rwvh_pkg::OUT_COUNT_W-1:0] count_r;
  logic [rwvh_pkg::PIXEL_W-1:0] pixel_r, pixel_nxt;

  logic                         oob;
  logic [AW-1:0]                item_addr;
  logic [COUNT_WIDTH-1:0]       ram_rdata, cnt_inc;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [COUNT_WIDTH-1:0]       ram_wdata;
  logic [CW-1:0]                nx, ny;
  logic                         off;
  logic [rwvh_pkg::PIX_PROD_W-1:0] pix_prod;

  rwvh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    oob = (kind_r == rwvh_pkg::KIND_READ) &&
          ((32'(cell_x_r) >= GRID_SIZE) || (32'(cell_y_r) >= GRID_SIZE));
    if (kind_r == rwvh_pkg::KIND_READ) begin
      item_addr = oob ? '0 :
                  AW'(32'(cell_y_r) * 32'(GRID_SIZE) + 32'(cell_x_r));
    end else begin
      item_addr = AW'(32'(walker_y_r) * 32'(GRID_SIZE) + 32'(walker_x_r));
    end
  end

  always_comb begin
    cnt_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
    if (kind_r == rwvh_pkg::KIND_READ) begin
      cnt_nxt = oob ? '0 : ram_rdata;
    end else begin
      cnt_nxt = cnt_inc;
    end
    ram_we    = cmd.clear || (cmd.calc && kind_r == rwvh_pkg::KIND_STEP);
    ram_waddr = cmd.clear ? clr_addr_r : item_addr;
    ram_wdata = cmd.clear ? '0 : cnt_inc;
  end

  always_comb begin
    nx  = walker_x_r;
    ny  = walker_y_r;
    off = 1'b0;
    unique case (dir_r)
      rwvh_pkg::DIR_NORTH: begin
        if (ny == '0) off = 1'b1;
        else ny = ny - CW'(1);
      end
      rwvh_pkg::DIR_EAST: begin
        if (32'(nx) + 32'd1 >= GRID_SIZE) off = 1'b1;
        else nx = nx + CW'(1);
      end
      rwvh_pkg::DIR_SOUTH: begin
        if (32'(ny) + 32'd1 >= GRID_SIZE) off = 1'b1;
        else ny = ny + CW'(1);
      end
      rwvh_pkg::DIR_WEST: begin
        if (nx == '0) off = 1'b1;
        else nx = nx - CW'(1);
      end
      default: begin
        off = 1'b1;
      end
    endcase

    walker_x_nxt = walker_x_r;
    walker_y_nxt = walker_y_r;
    steps_nxt    = steps_r;
    if (cmd.calc && kind_r == rwvh_pkg::KIND_STEP) begin
      if (steps_r > step_limit_r) begin
        walker_x_nxt = clamp_coord(start_x_r);
        walker_y_nxt = clamp_coord(start_y_r);
        steps_nxt    = '0;
      end else begin
        if (off) begin
          walker_x_nxt = clamp_coord(start_x_r);
          walker_y_nxt = clamp_coord(start_y_r);
        end else begin
          walker_x_nxt = nx;
          walker_y_nxt = ny;
        end
        steps_nxt = steps_r + rwvh_pkg::LIMIT_W'(1);
      end
    end
  end

  always_comb begin
    pix_prod = rwvh_pkg::PIX_PROD_W'(rwvh_pkg::PIX_IN_W'(cnt_r)) *
               rwvh_pkg::PIX_PROD_W'(rwvh_pkg::PIX_RECIP);
    if (64'(cnt_r) >= rwvh_pkg::PIX_SAT) begin
      pixel_nxt = rwvh_pkg::PIX_MAX;
    end else begin
      pixel_nxt = rwvh_pkg::PIXEL_W'(pix_prod >> rwvh_pkg::PIX_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= rwvh_pkg::START_X_RST;
      start_y_r    <= rwvh_pkg::START_Y_RST;
      step_limit_r <= rwvh_pkg::STEP_LIMIT_RST;
      walker_x_r   <= clamp_coord(rwvh_pkg::START_X_RST);
      walker_y_r   <= clamp_coord(rwvh_pkg::START_Y_RST);
      steps_r      <= '0;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rwvh_pkg::REG_START_X:    start_x_r    <= cfg_data[rwvh_pkg::COORD_W-1:0];
          rwvh_pkg::REG_START_Y:    start_y_r    <= cfg_data[rwvh_pkg::COORD_W-1:0];
          rwvh_pkg::REG_STEP_LIMIT: step_limit_r <= cfg_data[rwvh_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      walker_x_r <= walker_x_nxt;
      walker_y_r <= walker_y_nxt;
      steps_r    <= steps_nxt;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= rwvh_pkg::kind_t'(in_kind);
      dir_r    <= rwvh_pkg::dir_t'(in_direction);
      cell_x_r <= in_cell_x;
      cell_y_r <= in_cell_y;
    end
    if (cmd.calc) begin
      cnt_r <= cnt_nxt;
    end
    if (cmd.pix) begin
      pos_x_r <= rwvh_pkg::COORD_W'(walker_x_r);
      pos_y_r <= rwvh_pkg::COORD_W'(walker_y_r);
      count_r <= rwvh_pkg::OUT_COUNT_W'(cnt_r);
      pixel_r <= pixel_nxt;
    end
  end

  assign stat.clear_done = (clr_addr_r == AW'(DEPTH - 1));
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_count = count_r;
  assign out_pixel = pixel_r;

endmodule

// ===== rtl/random_walk_visit_histogram.sv =====
// Top level of the random walk visit histogram.
// Each item (walk step or cell read) goes through accept, histogram RAM read, update and
// write back, and pixel computation; the controller handles one item at a time around the
// registered read of the histogram RAM. The result is registered at the end of the pixel
// step, and the next item can be accepted in the same cycle that the result appears; a
// result that is not taken holds the next item in its pixel cycle. After reset a clearing
// pass writes zero to every cell, one cell per cycle; no item is accepted during it.
// Configuration writes are accepted in every cycle.
module random_walk_visit_histogram #(
  parameter int GRID_SIZE   = rwvh_pkg::GRID_SIZE_DEF,
  parameter int COUNT_WIDTH = rwvh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic [1:0]                       in_direction,
  input  logic [rwvh_pkg::COORD_W-1:0]     in_cell_x,
  input  logic [rwvh_pkg::COORD_W-1:0]     in_cell_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rwvh_pkg::COORD_W-1:0]     out_pos_x,
  output logic [rwvh_pkg::COORD_W-1:0]     out_pos_y,
  output logic [rwvh_pkg::OUT_COUNT_W-1:0] out_count,
  output logic [rwvh_pkg::PIXEL_W-1:0]     out_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rwvh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwvh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rwvh_pkg::cmd_t  cmd;
  rwvh_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rwvh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rwvh_dp #(
    .GRID_SIZE   (GRID_SIZE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_kind),
    .in_direction (in_direction),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_count    (out_count),
    .out_pixel    (out_pixel),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule

// ===== rtl/rwvh_checker.sv =====
// Port-level checker of the random walk visit histogram and its bind.
module rwvh_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [rwvh_pkg::COORD_W-1:0]     out_pos_x,
  input logic [rwvh_pkg::COORD_W-1:0]     out_pos_y,
  input logic [rwvh_pkg::OUT_COUNT_W-1:0] out_count,
  input logic [rwvh_pkg::PIXEL_W-1:0]     out_pixel
);

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item was accepted");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("block not ready for the next item once a result is shown");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_pixel)
      && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("stalled result changed or dropped");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind random_walk_visit_histogram rwvh_checker u_rwvh_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for the random walk visit histogram: directed and random items with a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000000;
  localparam int REPORT_MAX     = 10;
  localparam int HOT_STEPS      = 450;
  localparam logic [rwvh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [rwvh_pkg::COORD_W-1:0]     pos_x;
    logic [rwvh_pkg::COORD_W-1:0]     pos_y;
    logic [rwvh_pkg::OUT_COUNT_W-1:0] count;
    logic [rwvh_pkg::PIXEL_W-1:0]     pixel;
  } visit_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_kind;
  logic [1:0]                       in_direction;
  logic [rwvh_pkg::COORD_W-1:0]     in_cell_x;
  logic [rwvh_pkg::COORD_W-1:0]     in_cell_y;
  logic                             out_valid;
  logic                             out_ready;
  logic [rwvh_pkg::COORD_W-1:0]     out_pos_x;
  logic [rwvh_pkg::COORD_W-1:0]     out_pos_y;
  logic [rwvh_pkg::OUT_COUNT_W-1:0] out_count;
  logic [rwvh_pkg::PIXEL_W-1:0]     out_pixel;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rwvh_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [rwvh_pkg::CFG_DATA_W-1:0]  cfg_data;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  logic [rwvh_pkg::COORD_W-1:0]     home_x;
  logic [rwvh_pkg::COORD_W-1:0]     home_y;
  logic [rwvh_pkg::LIMIT_W-1:0]     restart_after;
  logic [rwvh_pkg::COORD_W-1:0]     at_x;
  logic [rwvh_pkg::COORD_W-1:0]     at_y;
  logic [rwvh_pkg::LIMIT_W-1:0]     walk_steps;
  logic [rwvh_pkg::OUT_COUNT_W-1:0] visits [logic [2*rwvh_pkg::COORD_W-1:0]];
  visit_result_t                    pending_results [$];

  random_walk_visit_histogram i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_direction (in_direction),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_count    (out_count),
    .out_pixel    (out_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic visit_result_t predict_visit(rwvh_pkg::kind_t kind, rwvh_pkg::dir_t dir,
                                                  logic [rwvh_pkg::COORD_W-1:0] cx,
                                                  logic [rwvh_pkg::COORD_W-1:0] cy);
    logic [rwvh_pkg::OUT_COUNT_W-1:0] c;
    int nx;
    int ny;
    if (kind == rwvh_pkg::KIND_READ) begin
      c = visits.exists({cy, cx}) ? visits[{cy, cx}] : '0;
    end else begin
      c = visits.exists({at_y, at_x}) ? visits[{at_y, at_x}] : '0;
      if (c != '1) c = c + 1'b1;
      visits[{at_y, at_x}] = c;
      if (walk_steps > restart_after) begin
        at_x = home_x;
        at_y = home_y;
        walk_steps = '0;
      end else begin
        nx = at_x;
        ny = at_y;
        case (dir)
          rwvh_pkg::DIR_NORTH: ny = ny - 1;
          rwvh_pkg::DIR_EAST:  nx = nx + 1;
          rwvh_pkg::DIR_SOUTH: ny = ny + 1;
          rwvh_pkg::DIR_WEST:  nx = nx - 1;
        endcase
        if (nx < 0 || ny < 0 || nx >= rwvh_pkg::GRID_SIZE_DEF ||
            ny >= rwvh_pkg::GRID_SIZE_DEF) begin
          at_x = home_x;
          at_y = home_y;
        end else begin
          at_x = rwvh_pkg::COORD_W'(nx);
          at_y = rwvh_pkg::COORD_W'(ny);
        end
        walk_steps = walk_steps + 1'b1;
      end
    end
    return '{at_x, at_y, c,
             (c / 10 > 255) ? rwvh_pkg::PIX_MAX : rwvh_pkg::PIXEL_W'(c / 10)};
  endfunction

  function automatic logic [rwvh_pkg::COORD_W-1:0] pick_home();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return rwvh_pkg::COORD_W'($urandom_range(0, rwvh_pkg::GRID_SIZE_DEF - 1));
    endcase
  endfunction

  task automatic flag_mismatch(string what, visit_result_t want, visit_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: expected x=%0d y=%0d count=%0d pixel=%0d, %s",
               $time, what, want.pos_x, want.pos_y, want.count, want.pixel,
               $sformatf("got x=%0d y=%0d count=%0d pixel=%0d",
                         got.pos_x, got.pos_y, got.count, got.pixel));
  endtask

  task automatic send_item(rwvh_pkg::kind_t kind, rwvh_pkg::dir_t dir,
                           logic [rwvh_pkg::COORD_W-1:0] cx,
                           logic [rwvh_pkg::COORD_W-1:0] cy);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_direction <= dir;
    in_cell_x    <= cx;
    in_cell_y    <= cy;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_visit(kind, dir, cx, cy));
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_walk(logic [rwvh_pkg::COORD_W-1:0] sx, logic [rwvh_pkg::COORD_W-1:0] sy,
                          logic [rwvh_pkg::LIMIT_W-1:0] lim, bit with_unused);
    logic [rwvh_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [rwvh_pkg::CFG_DATA_W-1:0] val [4];
    idx = '{rwvh_pkg::REG_START_X, rwvh_pkg::REG_START_Y, rwvh_pkg::REG_STEP_LIMIT,
            REG_UNUSED};
    val = '{{6'($urandom_range(0, 63)), sx}, {6'($urandom_range(0, 63)), sy}, lim,
            rwvh_pkg::CFG_DATA_W'($urandom)};
    for (int r = 0; r < (with_unused ? 4 : 3); r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      do @(posedge clk); while (!cfg_ready);
      case (idx[r])
        rwvh_pkg::REG_START_X:    home_x = val[r][rwvh_pkg::COORD_W-1:0];
        rwvh_pkg::REG_START_Y:    home_y = val[r][rwvh_pkg::COORD_W-1:0];
        rwvh_pkg::REG_STEP_LIMIT: restart_after = val[r];
        default:                  ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_WEST, '0, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_NORTH, '1, '1);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_NORTH, '1, '1);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_EAST, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_SOUTH, '1, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_WEST, '0, '1);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_NORTH, '0, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_SOUTH, 10'd512, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_EAST, 10'd513, '0);
    settle();
    set_walk('1, '1, '0, 1'b1);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_EAST, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_EAST, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_SOUTH, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_NORTH, '0, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_WEST, '1, '1);
    settle();
    set_walk('0, '0, '1, 1'b0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_SOUTH, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_EAST, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_WEST, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_NORTH, '0, '0);
    send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_SOUTH, '0, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_NORTH, '0, '0);
    send_item(rwvh_pkg::KIND_READ, rwvh_pkg::DIR_EAST, '1, 10'd1022);
  endtask

  task automatic test_random_walks();
    logic [rwvh_pkg::LIMIT_W-1:0] limits [7];
    logic [rwvh_pkg::COORD_W-1:0] rx;
    logic [rwvh_pkg::COORD_W-1:0] ry;
    limits = '{16'd0, 16'd1, 16'd3, 16'd12, 16'd60, rwvh_pkg::STEP_LIMIT_RST, '1};
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      set_walk(pick_home(), pick_home(), limits[ph], ph == 4);
      calm = (ph == 3);
      repeat (80) begin
        if ($urandom_range(0, 99) < 22) begin
          if ($urandom_range(0, 1)) begin
            rx = at_x + rwvh_pkg::COORD_W'($urandom_range(0, 4)) - rwvh_pkg::COORD_W'(2);
            ry = at_y + rwvh_pkg::COORD_W'($urandom_range(0, 4)) - rwvh_pkg::COORD_W'(2);
          end else begin
            rx = rwvh_pkg::COORD_W'($urandom);
            ry = rwvh_pkg::COORD_W'($urandom);
          end
          send_item(rwvh_pkg::KIND_READ, rwvh_pkg::dir_t'($urandom_range(0, 3)), rx, ry);
        end else begin
          send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::dir_t'($urandom_range(0, 3)),
                    rwvh_pkg::COORD_W'($urandom), rwvh_pkg::COORD_W'($urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0)
        send_item(rwvh_pkg::KIND_READ, rwvh_pkg::dir_t'($urandom_range(0, 3)), at_x, at_y);
      else
        send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::dir_t'($urandom_range(0, 3)),
                  rwvh_pkg::COORD_W'($urandom), rwvh_pkg::COORD_W'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic test_hot_cell();
    settle();
    set_walk('0, '0, '0, 1'b0);
    while (at_x != '0 || at_y != '0)
      send_item(rwvh_pkg::KIND_STEP, rwvh_pkg::DIR_NORTH, '0, '0);
    settle();
    set_walk('0, '0, '1, 1'b0);
    for (int n = 1; n <= HOT_STEPS; n++) begin
      send_item(rwvh_pkg::KIND_STEP,
                $urandom_range(0, 1) ? rwvh_pkg::DIR_NORTH : rwvh_pkg::DIR_WEST,
                rwvh_pkg::COORD_W'($urandom), rwvh_pkg::COORD_W'($urandom));
      if (n % 100 == 0)
        send_item(rwvh_pkg::KIND_READ, rwvh_pkg::dir_t'($urandom_range(0, 3)), '0, '0);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin : result_check
    visit_result_t got;
    visit_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_count, out_pixel};
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.count !== want.count || got.pixel !== want.pixel)
          flag_mismatch("item mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = rwvh_pkg::KIND_STEP;
    in_direction = rwvh_pkg::DIR_NORTH;
    in_cell_x    = '0;
    in_cell_y    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = rwvh_pkg::REG_START_X;
    cfg_data     = '0;
    home_x        = rwvh_pkg::START_X_RST;
    home_y        = rwvh_pkg::START_Y_RST;
    restart_after = rwvh_pkg::STEP_LIMIT_RST;
    at_x          = rwvh_pkg::START_X_RST;
    at_y          = rwvh_pkg::START_Y_RST;
    walk_steps    = '0;
    visits.delete();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_walks();
    test_backpressure();
    test_hot_cell();
    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
